// ===== rtl/drive_command_controller_assert.svh =====
// Assertion macros used by the checker file of the drive command controller.
`ifndef DRIVE_COMMAND_CONTROLLER_ASSERT_SVH
`define DRIVE_COMMAND_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/dcc_pkg.sv =====
`timescale 1ns / 1ps

package dcc_pkg;

  localparam int MUL_W = 16;

  typedef struct packed {
    logic [7:0]  min_speed;
    logic [15:0] blink_period;
  } cfg_t;

  localparam logic [2:0]  CFG_ADDR_MSB     = 3'd4;
  localparam logic        REG_MIN_SPEED    = 1'b0;
  localparam logic        REG_BLINK_PERIOD = 1'b1;
  localparam logic [7:0]  MIN_SPEED_RST    = 8'd100;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd333;

  typedef enum logic [3:0] {
    MODE_STOP      = 4'd0,
    MODE_FWD       = 4'd1,
    MODE_REV       = 4'd2,
    MODE_SPIN_L    = 4'd3,
    MODE_SPIN_R    = 4'd4,
    MODE_FWD_L     = 4'd5,
    MODE_FWD_R     = 4'd6,
    MODE_REV_L     = 4'd7,
    MODE_REV_R     = 4'd8
  } mode_t;

  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_V_UP = 8'h56;
  localparam logic [7:0] CH_V_LO = 8'h76;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [3:0] SPEED_MAX = 4'd10;
  localparam logic [7:0] DUTY_MAX  = 8'd255;

  // Reciprocal multipliers for the constant divisions, exact over the ranges used.
  localparam logic [MUL_W-1:0] DIV10_RECIP = 16'd205;
  localparam int               DIV10_SHIFT = 11;
  localparam logic [MUL_W-1:0] DIV5_RECIP  = 16'd52429;
  localparam int               DIV5_SHIFT  = 18;
  localparam logic [MUL_W-1:0] DIV3_RECIP  = 16'd171;
  localparam int               DIV3_SHIFT  = 9;

  localparam logic [15:0] NEAR_Q4  = 16'd192;
  localparam logic [15:0] HALT_Q4  = 16'd112;
  localparam logic [3:0]  NEAR_CM  = 4'd12;

  typedef struct packed {
    logic       mode_set;
    mode_t      mode;
    logic       speed_set;
    logic [3:0] speed;
    logic       head_set;
    logic       head;
  } dec_t;

  function automatic logic is_forward(input mode_t m);
    return (m == MODE_FWD) || (m == MODE_FWD_L) || (m == MODE_FWD_R);
  endfunction

  function automatic dec_t decode_byte(input logic [7:0] c);
    dec_t       d;
    logic [7:0] digit;
    d = '{mode_set: 1'b0, mode: MODE_STOP, speed_set: 1'b0, speed: 4'd0,
          head_set: 1'b0, head: 1'b0};
    digit = c - CH_0;
    unique case (c)
      CH_S, CH_D: begin d.mode_set = 1'b1; d.mode = MODE_STOP;   end
      CH_F:       begin d.mode_set = 1'b1; d.mode = MODE_FWD;    end
      CH_B:       begin d.mode_set = 1'b1; d.mode = MODE_REV;    end
      CH_L:       begin d.mode_set = 1'b1; d.mode = MODE_SPIN_L; end
      CH_R:       begin d.mode_set = 1'b1; d.mode = MODE_SPIN_R; end
      CH_G:       begin d.mode_set = 1'b1; d.mode = MODE_FWD_L;  end
      CH_I:       begin d.mode_set = 1'b1; d.mode = MODE_FWD_R;  end
      CH_H:       begin d.mode_set = 1'b1; d.mode = MODE_REV_L;  end
      CH_J:       begin d.mode_set = 1'b1; d.mode = MODE_REV_R;  end
      CH_Q:       begin d.speed_set = 1'b1; d.speed = SPEED_MAX; end
      CH_V_UP:    begin d.head_set = 1'b1; d.head = 1'b1;        end
      CH_V_LO:    begin d.head_set = 1'b1; d.head = 1'b0;        end
      default: begin
        if (c >= CH_0 && c <= CH_9) begin
          d.speed_set = 1'b1;
          d.speed     = digit[3:0];
        end
      end
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/dcc_mul.sv =====
`timescale 1ns / 1ps

module dcc_mul (
  input  logic                           clk,
  input  logic [dcc_pkg::MUL_W-1:0]      mul_a,
  input  logic [dcc_pkg::MUL_W-1:0]      mul_b,
  output logic [2*dcc_pkg::MUL_W-1:0]    prod
);
  import dcc_pkg::*;

  logic [2*MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/dcc_cfg.sv =====
`timescale 1ns / 1ps

module dcc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output dcc_pkg::cfg_t cfg
);
  import dcc_pkg::*;

  logic [7:0]  min_speed_r, min_speed_nxt;
  logic [15:0] blink_period_r, blink_period_nxt;
  logic        wr_en;
  logic        reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = |(cfg_paddr & CFG_ADDR_MSB);

  always_comb begin
    min_speed_nxt    = min_speed_r;
    blink_period_nxt = blink_period_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MIN_SPEED:    min_speed_nxt    = cfg_pwdata[7:0];
        REG_BLINK_PERIOD: blink_period_nxt = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r    <= MIN_SPEED_RST;
      blink_period_r <= BLINK_PERIOD_RST;
    end else begin
      min_speed_r    <= min_speed_nxt;
      blink_period_r <= blink_period_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_SPEED:    cfg_prdata = {24'd0, min_speed_r};
      REG_BLINK_PERIOD: cfg_prdata = {16'd0, blink_period_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.min_speed    = min_speed_r;
  assign cfg.blink_period = blink_period_r;

endmodule

// ===== rtl/drive_command_controller.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid / in_tready  tdata: command, sensors, time; tuser: byte flag
// out_     master     out_tvalid / out_tready tdata: four duties, lamps, edge alert
// cfg_     APB slave  psel, penable, pready  min_speed at 0x0, blink_period at 0x4
//
// A transaction is taken in idle; its result is registered after the steps LAMP, STEP,
// DUTY, SCALE, NEAR and INNER, and the next one is taken only once the block is idle again.
// The steps run in order because the single shared multiplier is used five times in a row.
// Reset is synchronous and active low and restores the config registers and the drive state.
// A stalled result stays in the output register; the last step waits while it is full.
module drive_command_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // rx_byte, edge_seen, distance_q4, now_ms, zero pad
  input  logic        in_tuser,   // byte_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // m1 fwd, m1 rev, m2 fwd, m2 rev, left, right,
                                  // headlights, edge_alert, zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LAMP, ST_STEP, ST_DUTY, ST_SCALE, ST_NEAR, ST_INNER
  } state_t;

  cfg_t               cfg;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;

  state_t      state_r, state_nxt;
  logic        byte_valid_r, byte_valid_nxt;
  logic [7:0]  rx_byte_r, rx_byte_nxt;
  logic        edge_r, edge_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [31:0] now_r, now_nxt;
  logic [7:0]  held_r, held_nxt;
  mode_t       mode_r, mode_nxt;
  logic [3:0]  speed_r, speed_nxt;
  logic [31:0] last_blink_r, last_blink_nxt;
  logic        left_r, left_nxt;
  logic        right_r, right_nxt;
  logic        head_r, head_nxt;
  logic [7:0]  duty_r, duty_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  logic [7:0]  hold;
  logic        due;
  dec_t        dec;
  mode_t       mode_dec;
  logic [8:0]  duty_sum;
  logic [3:0]  near_k;
  logic        near;
  logic [7:0]  duty_fin;
  logic [7:0]  inner;
  logic [7:0]  m1f, m1r, m2f, m2r;

  dcc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dcc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign hold     = byte_valid_r ? rx_byte_r : held_r;
  assign due      = (now_r - last_blink_r) >= {16'd0, cfg.blink_period};
  assign dec      = decode_byte(hold);
  assign mode_dec = dec.mode_set ? dec.mode : mode_r;
  assign duty_sum = {1'b0, cfg.min_speed} + {1'b0, prod[7:0]};
  assign near_k   = NEAR_CM - dist_r[7:4];
  assign near     = (dist_r < NEAR_Q4) && is_forward(mode_r);
  assign inner    = prod[DIV3_SHIFT+7:DIV3_SHIFT];

  always_comb begin
    if (!near) begin
      duty_fin = duty_r;
    end else if (dist_r < HALT_Q4) begin
      duty_fin = 8'd0;
    end else begin
      duty_fin = duty_r - prod[DIV5_SHIFT+7:DIV5_SHIFT];
    end
  end

  // Shared multiplier operands for each step of the sequence.
  always_comb begin
    unique case (state_r)
      ST_LAMP: begin
        mul_a = {8'd0, DUTY_MAX - cfg.min_speed};
        mul_b = DIV10_RECIP;
      end
      ST_STEP: begin
        mul_a = {11'd0, prod[DIV10_SHIFT+4:DIV10_SHIFT]};
        mul_b = {12'd0, speed_r};
      end
      ST_DUTY: begin
        mul_a = {12'd0, near_k};
        mul_b = {8'd0, duty_sum[8] ? DUTY_MAX : duty_sum[7:0]};
      end
      ST_SCALE: begin
        mul_a = {4'd0, prod[11:0]};
        mul_b = DIV5_RECIP;
      end
      ST_NEAR: begin
        mul_a = {8'd0, duty_fin};
        mul_b = DIV3_RECIP;
      end
      ST_INNER: begin
        mul_a = {8'd0, duty_r};
        mul_b = DIV3_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    m1f = 8'd0;
    m1r = 8'd0;
    m2f = 8'd0;
    m2r = 8'd0;
    unique case (mode_r)
      MODE_FWD:    begin m1f = duty_r; m2f = duty_r; end
      MODE_REV:    begin m1r = duty_r; m2r = duty_r; end
      MODE_SPIN_L: begin m1r = duty_r; m2f = duty_r; end
      MODE_SPIN_R: begin m1f = duty_r; m2r = duty_r; end
      MODE_FWD_L:  begin m1f = inner;  m2f = duty_r; end
      MODE_FWD_R:  begin m1f = duty_r; m2f = inner;  end
      MODE_REV_L:  begin m1r = duty_r; m2r = inner;  end
      MODE_REV_R:  begin m1r = inner;  m2r = duty_r; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    byte_valid_nxt = byte_valid_r;
    rx_byte_nxt    = rx_byte_r;
    edge_nxt       = edge_r;
    dist_nxt       = dist_r;
    now_nxt        = now_r;
    held_nxt       = held_r;
    mode_nxt       = mode_r;
    speed_nxt      = speed_r;
    last_blink_nxt = last_blink_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    head_nxt       = head_r;
    duty_nxt       = duty_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_valid_nxt = in_tuser;
          rx_byte_nxt    = in_tdata[7:0];
          edge_nxt       = in_tdata[8];
          dist_nxt       = in_tdata[24:9];
          now_nxt        = in_tdata[56:25];
          state_nxt      = ST_LAMP;
        end
      end
      ST_LAMP: begin
        held_nxt = hold;
        unique case (hold)
          CH_L, CH_G: begin
            if (due) begin
              last_blink_nxt = now_r;
              left_nxt       = ~left_r;
            end
            right_nxt = 1'b0;
          end
          CH_R, CH_I: begin
            if (due) begin
              last_blink_nxt = now_r;
              right_nxt      = ~right_r;
            end
            left_nxt = 1'b0;
          end
          default: begin
            left_nxt  = 1'b0;
            right_nxt = 1'b0;
          end
        endcase
        if (dec.speed_set) begin
          speed_nxt = dec.speed;
        end
        if (dec.head_set) begin
          head_nxt = dec.head;
        end
        mode_nxt  = (edge_r && is_forward(mode_dec)) ? MODE_STOP : mode_dec;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        state_nxt = ST_DUTY;
      end
      ST_DUTY: begin
        duty_nxt  = duty_sum[8] ? DUTY_MAX : duty_sum[7:0];
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_NEAR;
      end
      ST_NEAR: begin
        duty_nxt  = duty_fin;
        state_nxt = ST_INNER;
      end
      ST_INNER: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, edge_r, head_r, right_r, left_r, m2r, m2f, m1r, m1f};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_r       <= 8'd0;
      mode_r       <= MODE_STOP;
      speed_r      <= 4'd0;
      last_blink_r <= 32'd0;
      left_r       <= 1'b0;
      right_r      <= 1'b0;
      head_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      mode_r       <= mode_nxt;
      speed_r      <= speed_nxt;
      last_blink_r <= last_blink_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      head_r       <= head_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    byte_valid_r <= byte_valid_nxt;
    rx_byte_r    <= rx_byte_nxt;
    edge_r       <= edge_nxt;
    dist_r       <= dist_nxt;
    now_r        <= now_nxt;
    duty_r       <= duty_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ===== rtl/dcc_checker.sv =====
`timescale 1ns / 1ps
`include "drive_command_controller_assert.svh"

module dcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic m1f_on, m1r_on, m2f_on, m2r_on;

  assign m1f_on = |out_tdata[7:0];
  assign m1r_on = |out_tdata[15:8];
  assign m2f_on = |out_tdata[23:16];
  assign m2r_on = |out_tdata[31:24];

  `DCC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `DCC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `DCC_ASSERT_IMP(a_lamps_exclusive, clk, rst_n, out_tvalid, !(out_tdata[32] && out_tdata[33]))
  `DCC_ASSERT_IMP(a_edge_no_forward, clk, rst_n, out_tvalid && out_tdata[35], !(m1f_on && m2f_on))
  `DCC_ASSERT_IMP(a_motor_direction, clk, rst_n, out_tvalid, !(m1f_on && m1r_on) && !(m2f_on && m2r_on))

endmodule

bind drive_command_controller dcc_checker u_dcc_checker (.*);
